@@ src/upwind_convection_diffusion_stencil_assert.svh @@
// Assertion macros for the upwind convection-diffusion stencil
`ifndef UPWIND_CONVECTION_DIFFUSION_STENCIL_ASSERT_SVH
`define UPWIND_CONVECTION_DIFFUSION_STENCIL_ASSERT_SVH

// checked outside reset
`define UCDS_CHECK(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("upwind stencil check failed");

// checked in every cycle, reset included
`define UCDS_CHECK_RST(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("upwind stencil reset check failed");

`endif

@@ src/ucds_pkg.sv @@
// Types and constants of the upwind convection-diffusion stencil
package ucds_pkg;

   localparam int FRAC_BITS = 16;
   localparam int MAX_GRID  = 1024;
   localparam int GW        = 11;
   localparam int QW        = FRAC_BITS + 1;
   localparam int DW        = 32;
   localparam int NW        = DW + QW;
   localparam int EXW       = 53;
   localparam int CW        = 56;
   localparam int CHALF     = 28;
   localparam int PW        = 96;
   localparam int TW        = QW + GW;

   localparam logic [1:0] CSR_GRID_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_GRID_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_DIFF_EPS    = 2'd2;
   localparam logic [1:0] CSR_FLOW_MODE   = 2'd3;

   localparam logic [1:0] FLOW_FIRST  = 2'd0;
   localparam logic [1:0] FLOW_SECOND = 2'd1;

   localparam logic [GW-1:0] GRID_RESET = GW'(64);
   localparam logic [31:0]   EPS_RESET  = 32'd65536;

   typedef struct packed {
      logic [10:0]        x_index;
      logic [10:0]        y_index;
      logic signed [31:0] u_center;
      logic signed [31:0] u_west;
      logic signed [31:0] u_east;
      logic signed [31:0] u_south;
      logic signed [31:0] u_north;
   } ucds_req_type;

   typedef struct packed {
      logic signed [63:0] stencil_value;
      logic [47:0]        center_coeff;
      logic               saturated;
   } ucds_rsp_type;

   typedef struct packed {
      logic [4:0][31:0]   u;
      logic [EXW-1:0]     exx;
      logic [EXW-1:0]     eyy;
      logic               sa;
      logic               sb;
   } ucds_side_type;

endpackage

@@ src/upwind_convection_diffusion_stencil.sv @@
// Top level: pipelined upwind convection-diffusion five-point stencil
//
//  channel  | ports                              | direction
//  request  | start, busy, req_data              | in (busy out)
//  result   | rsp_strobe, rsp_data               | out
//  config   | csr_we, csr_index, csr_wdata       | in
//
// One request per cycle; results leave in request order.
// The velocities a and b come from restoring dividers, one quotient bit per stage.
// Synchronous reset empties the pipeline; busy is high only during reset.
// The result side cannot stall, so the pipeline always advances.
module upwind_convection_diffusion_stencil
   import ucds_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  ucds_req_type req_data,
   output logic         rsp_strobe,
   output ucds_rsp_type rsp_data,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

`include "upwind_convection_diffusion_stencil_assert.svh"

   localparam logic [QW-1:0] ONE = QW'(1 << FRAC_BITS);

   // configuration
   logic [GW-1:0] gw_ff, gh_ff;
   logic [31:0]   eps_ff;
   logic [1:0]    mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gw_ff   <= GRID_RESET;
         gh_ff   <= GRID_RESET;
         eps_ff  <= EPS_RESET;
         mode_ff <= FLOW_FIRST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_GRID_WIDTH:  gw_ff   <= csr_wdata[GW-1:0];
            CSR_GRID_HEIGHT: gh_ff   <= csr_wdata[GW-1:0];
            CSR_DIFF_EPS:    eps_ff  <= csr_wdata;
            CSR_FLOW_MODE:   mode_ff <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   logic [GW-1:0] nx, ny;
   logic          unit_flow;
   always_comb begin
      nx = (gw_ff == '0) ? GW'(1) : ((gw_ff > GW'(MAX_GRID)) ? GW'(MAX_GRID) : gw_ff);
      ny = (gh_ff == '0) ? GW'(1) : ((gh_ff > GW'(MAX_GRID)) ? GW'(MAX_GRID) : gh_ff);
      unit_flow = (mode_ff != FLOW_FIRST) && (mode_ff != FLOW_SECOND);
   end

   logic accept;
   assign busy   = reset;
   assign accept = start && !busy;

   // stage 1: clamp and first products
   logic [GW-1:0]      xc, yc;
   logic signed [12:0] xs, ys, nxs, nys, dx;
   logic signed [25:0] px1, py1;
   logic [21:0]        xx, xy;
   logic signed [22:0] pa_in, pb_in;
   logic signed [12:0] fa_in, fb_in;

   always_comb begin
      xc  = (req_data.x_index > nx) ? nx : req_data.x_index;
      yc  = (req_data.y_index > ny) ? ny : req_data.y_index;
      xs  = $signed({2'b00, xc});
      ys  = $signed({2'b00, yc});
      nxs = $signed({2'b00, nx});
      nys = $signed({2'b00, ny});
      dx  = xs - nxs;
      xx  = xc * xc;
      xy  = xc * yc;
      px1 = xs * dx;
      py1 = ys * (nys - ys);
      if (mode_ff == FLOW_FIRST) begin
         pa_in = $signed(23'(nx * nx) - 23'(xx));
         fa_in = $signed({1'b0, yc, 1'b0}) - nys;
         pb_in = $signed({1'b0, xy[20:0], 1'b0});
         fb_in = ys - nys;
      end else begin
         pa_in = $signed({px1[20:0], 2'b00});
         fa_in = nys - $signed({1'b0, yc, 1'b0});
         pb_in = $signed({py1[20:0], 2'b00});
         fb_in = nxs - $signed({1'b0, xc, 1'b0});
      end
   end

   logic               v1_ff;
   logic signed [22:0] pa_ff, pb_ff;
   logic signed [12:0] fa_ff, fb_ff;
   logic [20:0]        nx2_ff, ny2_ff;
   logic [4:0][31:0]   u1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
      end
      pa_ff  <= pa_in;
      pb_ff  <= pb_in;
      fa_ff  <= fa_in;
      fb_ff  <= fb_in;
      nx2_ff <= 21'(nx * nx);
      ny2_ff <= 21'(ny * ny);
      u1_ff  <= {req_data.u_center, req_data.u_west, req_data.u_east,
                 req_data.u_south, req_data.u_north};
   end

   // stage 2: numerators, denominators, diffusion terms
   logic               v2_ff;
   logic signed [35:0] numa_ff, numb_ff;
   logic [DW-1:0]      dna_ff, dnb_ff;
   logic [EXW-1:0]     exx_ff, eyy_ff;
   logic [4:0][31:0]   u2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      numa_ff <= pa_ff * fa_ff;
      numb_ff <= pb_ff * fb_ff;
      dna_ff  <= DW'(nx2_ff * ny);
      dnb_ff  <= DW'(ny2_ff * nx);
      exx_ff  <= EXW'(eps_ff * nx2_ff);
      eyy_ff  <= EXW'(eps_ff * ny2_ff);
      u2_ff   <= u1_ff;
   end

   // stage 3: divider set-up, rounding offset folded into the dividend
   logic [35:0] maga_in, magb_in;
   always_comb begin
      maga_in = numa_ff[35] ? 36'(-numa_ff) : 36'(numa_ff);
      magb_in = numb_ff[35] ? 36'(-numb_ff) : 36'(numb_ff);
   end

   logic [NW-1:0]   rema_ff [QW];
   logic [NW-1:0]   remb_ff [QW];
   logic [DW-1:0]   da_ff   [QW];
   logic [DW-1:0]   db_ff   [QW];
   logic [QW-1:0]   qa_ff   [QW];
   logic [QW-1:0]   qb_ff   [QW];
   logic            dv_ff   [QW+1];
   ucds_side_type   sd_ff   [QW+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else begin
         dv_ff[0] <= v2_ff;
      end
      rema_ff[0]  <= (NW'(maga_in) << QW) + NW'(dna_ff);
      remb_ff[0]  <= (NW'(magb_in) << QW) + NW'(dnb_ff);
      da_ff[0]    <= {dna_ff[DW-2:0], 1'b0};
      db_ff[0]    <= {dnb_ff[DW-2:0], 1'b0};
      sd_ff[0].u   <= u2_ff;
      sd_ff[0].exx <= exx_ff;
      sd_ff[0].eyy <= eyy_ff;
      sd_ff[0].sa  <= numa_ff[35];
      sd_ff[0].sb  <= numb_ff[35];
   end

   // restoring division, one quotient bit per stage
   for (genvar i = 0; i < QW; i++) begin : g_div
      localparam int K = QW - 1 - i;
      logic [NW-1:0] sha, shb;
      logic          gea, geb;
      logic [QW-1:0] qpa, qpb;

      always_comb begin
         sha = NW'(da_ff[i]) << K;
         shb = NW'(db_ff[i]) << K;
         gea = rema_ff[i] >= sha;
         geb = remb_ff[i] >= shb;
      end

      if (i == 0) begin : g_first
         assign qpa = '0;
         assign qpb = '0;
      end else begin : g_rest
         assign qpa = qa_ff[i-1];
         assign qpb = qb_ff[i-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[i+1] <= 1'b0;
         end else begin
            dv_ff[i+1] <= dv_ff[i];
         end
         qa_ff[i]   <= {qpa[QW-2:0], gea};
         qb_ff[i]   <= {qpb[QW-2:0], geb};
         sd_ff[i+1] <= sd_ff[i];
      end

      if (i < QW - 1) begin : g_pass
         always_ff @(posedge clock) begin
            rema_ff[i+1] <= gea ? rema_ff[i] - sha : rema_ff[i];
            remb_ff[i+1] <= geb ? remb_ff[i] - shb : remb_ff[i];
            da_ff[i+1]   <= da_ff[i];
            db_ff[i+1]   <= db_ff[i];
         end
      end
   end

   // stage A: velocity magnitudes times grid size
   logic [QW-1:0] qa, qb, aabs_in, babs_in;
   logic          apos_in, aneg_in, bpos_in, bneg_in;

   always_comb begin
      qa      = qa_ff[QW-1];
      qb      = qb_ff[QW-1];
      aabs_in = unit_flow ? ONE : qa;
      babs_in = unit_flow ? ONE : qb;
      aneg_in = !unit_flow && sd_ff[QW].sa && (qa != '0);
      bneg_in = !unit_flow && sd_ff[QW].sb && (qb != '0);
      apos_in = unit_flow || (!sd_ff[QW].sa && (qa != '0));
      bpos_in = unit_flow || (!sd_ff[QW].sb && (qb != '0));
   end

   logic             va_ff, apos_ff, aneg_ff, bpos_ff, bneg_ff;
   logic [TW-1:0]    ta_ff, tb_ff;
   ucds_side_type    sa_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else begin
         va_ff <= dv_ff[QW];
      end
      ta_ff   <= aabs_in * nx;
      tb_ff   <= babs_in * ny;
      apos_ff <= apos_in;
      aneg_ff <= aneg_in;
      bpos_ff <= bpos_in;
      bneg_ff <= bneg_in;
      sa_ff   <= sd_ff[QW];
   end

   // stage B: coefficients
   logic signed [CW-1:0] ex_in, ey_in, ta_in, tb_in;
   logic signed [CW-1:0] coef_in [5];

   always_comb begin
      ex_in = $signed(CW'(sa_ff.exx));
      ey_in = $signed(CW'(sa_ff.eyy));
      ta_in = $signed(CW'(ta_ff));
      tb_in = $signed(CW'(tb_ff));
      coef_in[0] = (ex_in <<< 1) + (ey_in <<< 1) + ta_in + tb_in;
      coef_in[1] = -ex_in - (apos_ff ? ta_in : '0);
      coef_in[2] = -ex_in - (aneg_ff ? ta_in : '0);
      coef_in[3] = -ey_in - (bpos_ff ? tb_in : '0);
      coef_in[4] = -ey_in - (bneg_ff ? tb_in : '0);
   end

   logic                 vb_ff, csat_ff;
   logic signed [CW-1:0] coef_ff [5];
   logic [4:0][31:0]     ub_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else begin
         vb_ff <= va_ff;
      end
      for (int j = 0; j < 5; j++) begin
         coef_ff[j] <= coef_in[j];
      end
      csat_ff <= coef_in[0] > $signed(CW'(48'hFFFF_FFFF_FFFF));
      ub_ff   <= sa_ff.u;
   end

   // stage C: split partial products
   logic              vc_ff, csat_c_ff;
   logic signed [60:0] plo_ff [5];
   logic signed [59:0] phi_ff [5];
   logic [47:0]        cen_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
      end else begin
         vc_ff <= vb_ff;
      end
      for (int j = 0; j < 5; j++) begin
         plo_ff[j] <= $signed({1'b0, coef_ff[j][CHALF-1:0]}) * $signed(ub_ff[4-j]);
         phi_ff[j] <= $signed(coef_ff[j][CW-1:CHALF]) * $signed(ub_ff[4-j]);
      end
      csat_c_ff <= csat_ff;
      cen_c_ff  <= csat_ff ? 48'hFFFF_FFFF_FFFF : coef_ff[0][47:0];
   end

   // stage D: full products
   logic               vd_ff, csat_d_ff;
   logic signed [PW-1:0] term_ff [5];
   logic [47:0]        cen_d_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vd_ff <= 1'b0;
      end else begin
         vd_ff <= vc_ff;
      end
      for (int j = 0; j < 5; j++) begin
         term_ff[j] <= (PW'(phi_ff[j]) <<< CHALF) + PW'(plo_ff[j]);
      end
      csat_d_ff <= csat_c_ff;
      cen_d_ff  <= cen_c_ff;
   end

   // stage E: partial sums
   logic                 ve_ff, csat_e_ff;
   logic signed [PW-1:0] s01_ff, s23_ff, s4_ff;
   logic [47:0]          cen_e_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ve_ff <= 1'b0;
      end else begin
         ve_ff <= vd_ff;
      end
      s01_ff    <= term_ff[0] + term_ff[1];
      s23_ff    <= term_ff[2] + term_ff[3];
      s4_ff     <= term_ff[4];
      csat_e_ff <= csat_d_ff;
      cen_e_ff  <= cen_d_ff;
   end

   // stage F: round, saturate, output register
   logic signed [PW-1:0] acc, sh;
   logic                 fits;
   logic signed [63:0]   val_in;

   always_comb begin
      acc  = s01_ff + s23_ff + s4_ff + $signed(PW'(1) << (FRAC_BITS - 1));
      sh   = acc >>> FRAC_BITS;
      fits = (sh[PW-1:63] == {(PW-63){sh[63]}});
      if (fits) begin
         val_in = sh[63:0];
      end else if (sh[PW-1]) begin
         val_in = {1'b1, 63'd0};
      end else begin
         val_in = {1'b0, {63{1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe <= 1'b0;
      end else begin
         rsp_strobe <= ve_ff;
      end
      rsp_data.stencil_value <= val_in;
      rsp_data.center_coeff  <= cen_e_ff;
      rsp_data.saturated     <= !fits || csat_e_ff;
   end

   logic signed [CW+2:0] coef_sum;
   assign coef_sum = (CW+3)'(coef_ff[0]) + (CW+3)'(coef_ff[1]) + (CW+3)'(coef_ff[2])
                   + (CW+3)'(coef_ff[3]) + (CW+3)'(coef_ff[4]);

   `UCDS_CHECK(a_coeff_balance, vb_ff |-> (coef_sum == '0))
   `UCDS_CHECK(a_quot_bound, dv_ff[QW] |-> (qa_ff[QW-1] <= ONE) && (qb_ff[QW-1] <= ONE))
   `UCDS_CHECK(a_center_clip, vb_ff && csat_ff |=> cen_c_ff == 48'hFFFF_FFFF_FFFF)
   `UCDS_CHECK_RST(a_reset_empty, reset |=> !rsp_strobe)

endmodule

@@ verif/tb_upwind_convection_diffusion_stencil.sv @@
// Testbench for the upwind convection-diffusion stencil: queued requests, predictor, checker
module tb_upwind_convection_diffusion_stencil;
   import ucds_pkg::*;

   localparam logic [1:0] FLOW_UNIT  = 2'd2;
   localparam logic [1:0] FLOW_SPARE = 2'd3;
   localparam int         CYCLE_LIMIT = 400000;
   localparam int         DRAIN_CYCLES = 40;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   ucds_req_type req_data = '0;
   logic         rsp_strobe;
   ucds_rsp_type rsp_data;
   logic         csr_we = 1'b0;
   logic [1:0]   csr_index = '0;
   logic [31:0]  csr_wdata = '0;

   ucds_req_type pending_reqs[$];
   ucds_rsp_type expected_rsps[$];
   int           req_gap = 0;
   int           mismatches = 0;
   int           cycles = 0;

   // register copy used by the predictor
   logic [10:0]  cfg_width = 11'd64;
   logic [10:0]  cfg_height = 11'd64;
   logic [31:0]  cfg_eps = 32'd65536;
   logic [1:0]   cfg_mode = FLOW_FIRST;

   upwind_convection_diffusion_stencil u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic longint grid_clamp(logic [10:0] g);
      if (g == 0) return 1;
      if (g > MAX_GRID) return MAX_GRID;
      return longint'(g);
   endfunction

   function automatic longint velocity_round(longint num, longint den);
      longint mag, q;
      mag = num < 0 ? -num : num;
      q = ((mag <<< (FRAC_BITS + 1)) + den) / (2 * den);
      return num < 0 ? -q : q;
   endfunction

   function automatic logic signed [127:0] coeff_product(longint c, logic signed [31:0] u);
      logic signed [127:0] cx, ux;
      cx = c;
      ux = u;
      return cx * ux;
   endfunction

   function automatic ucds_rsp_type stencil_predict(ucds_req_type r);
      longint nx, ny, px, py, a, b, eps, exx, eyy, cc, cw, ce, cs, cn;
      logic signed [127:0] acc, sh;
      ucds_rsp_type res;
      nx = grid_clamp(cfg_width);
      ny = grid_clamp(cfg_height);
      px = longint'(r.x_index);
      py = longint'(r.y_index);
      if (px > nx) px = nx;
      if (py > ny) py = ny;
      if (cfg_mode == FLOW_FIRST) begin
         a = velocity_round((2 * py - ny) * (nx * nx - px * px), ny * nx * nx);
         b = velocity_round(2 * px * py * (py - ny), nx * ny * ny);
      end else if (cfg_mode == FLOW_SECOND) begin
         a = velocity_round(4 * px * (px - nx) * (ny - 2 * py), nx * nx * ny);
         b = velocity_round(4 * py * (ny - py) * (nx - 2 * px), ny * ny * nx);
      end else begin
         a = longint'(1) <<< FRAC_BITS;
         b = a;
      end
      eps = longint'({32'b0, cfg_eps});
      exx = eps * nx * nx;
      eyy = eps * ny * ny;
      cc = 2 * exx + 2 * eyy + (a < 0 ? -a : a) * nx + (b < 0 ? -b : b) * ny;
      cw = -exx - (a > 0 ? a : 0) * nx;
      ce = -exx + (a < 0 ? a : 0) * nx;
      cs = -eyy - (b > 0 ? b : 0) * ny;
      cn = -eyy + (b < 0 ? b : 0) * ny;
      acc = coeff_product(cc, r.u_center) + coeff_product(cw, r.u_west)
          + coeff_product(ce, r.u_east) + coeff_product(cs, r.u_south)
          + coeff_product(cn, r.u_north) + 128'sd32768;
      sh = acc >>> FRAC_BITS;
      res.saturated = 1'b0;
      if (sh[127:63] == '0 || sh[127:63] == '1) begin
         res.stencil_value = sh[63:0];
      end else begin
         res.saturated = 1'b1;
         res.stencil_value = sh[127] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      end
      if (cc > longint'(48'hFFFF_FFFF_FFFF)) begin
         res.center_coeff = 48'hFFFF_FFFF_FFFF;
         res.saturated = 1'b1;
      end else begin
         res.center_coeff = cc[47:0];
      end
      return res;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !busy) begin
         if (req_gap == 0 && pending_reqs.size() != 0) begin
            req_data <= pending_reqs.pop_front();
            req_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
         end else begin
            start <= 1'b0;
         end
      end else if (!start) begin
         if (req_gap != 0) begin
            req_gap <= req_gap - 1;
         end else if (pending_reqs.size() != 0) begin
            req_data <= pending_reqs.pop_front();
            start <= 1'b1;
            req_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
         end
      end
   end

   // predictor and register copy
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) expected_rsps.push_back(stencil_predict(req_data));
         if (csr_we) begin
            case (csr_index)
               CSR_GRID_WIDTH: cfg_width <= csr_wdata[10:0];
               CSR_GRID_HEIGHT: cfg_height <= csr_wdata[10:0];
               CSR_DIFF_EPS: cfg_eps <= csr_wdata;
               CSR_FLOW_MODE: cfg_mode <= csr_wdata[1:0];
               default: ;
            endcase
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      ucds_rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", rsp_data);
         end else begin
            want = expected_rsps.pop_front();
            if (want.stencil_value !== rsp_data.stencil_value
                  || want.center_coeff !== rsp_data.center_coeff
                  || want.saturated !== rsp_data.saturated) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: value exp %h got %h, centre exp %h got %h, sat exp %b got %b",
                     want.stencil_value, rsp_data.stencil_value, want.center_coeff,
                     rsp_data.center_coeff, want.saturated, rsp_data.saturated);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("upwind_convection_diffusion_stencil verification failed");
         $finish;
      end
   end

   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_grid(logic [10:0] w, logic [10:0] h, logic [31:0] e, logic [1:0] m);
      csr_write(CSR_GRID_WIDTH, {21'b0, w});
      csr_write(CSR_GRID_HEIGHT, {21'b0, h});
      csr_write(CSR_DIFF_EPS, e);
      csr_write(CSR_FLOW_MODE, {30'b0, m});
   endtask

   function automatic logic [31:0] point_value();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'($urandom_range(0, 32'h3FFFF)) - 32'h20000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [10:0] grid_index(logic [10:0] g);
      if ($urandom_range(0, 9) == 0) return 11'($urandom_range(0, 2047));
      return 11'($urandom_range(0, 32'(grid_clamp(g))));
   endfunction

   task automatic push_point(logic [10:0] x, logic [10:0] y, logic [31:0] uc, logic [31:0] uw,
                             logic [31:0] ue, logic [31:0] us, logic [31:0] un);
      ucds_req_type r;
      r.x_index = x; r.y_index = y;
      r.u_center = uc; r.u_west = uw; r.u_east = ue; r.u_south = us; r.u_north = un;
      pending_reqs.push_back(r);
   endtask

   task automatic run_points(int n);
      repeat (n)
         push_point(grid_index(cfg_width), grid_index(cfg_height), point_value(),
                    point_value(), point_value(), point_value(), point_value());
      do @(posedge clock);
      while (pending_reqs.size() != 0 || start || expected_rsps.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: corners, centre, beyond the grid, extreme values
      push_point(0, 0, 32'h0001_0000, 0, 0, 0, 0);
      push_point(64, 64, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                 32'h0001_0000);
      push_point(32, 32, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000);
      push_point(32, 16, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF);
      push_point(11'h7FF, 11'h7FF, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF);
      push_point(1024, 0, 32'h1234_5678, 32'h8765_4321, 0, 32'h7FFF_FFFF, 32'h8000_0000);
      push_point(0, 63, 32'hFFFF_0000, 32'h0000_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 0);
      push_point(48, 8, 0, 0, 0, 0, 0);
      run_points(100);
      set_grid(11'd2, 11'd2, 32'd0, FLOW_FIRST);
      run_points(100);
      set_grid(11'd1024, 11'd1024, 32'hFFFF_FFFF, FLOW_SECOND);
      run_points(120);
      set_grid(11'd0, 11'd2047, 32'd1, FLOW_UNIT);
      run_points(100);
      set_grid(11'd37, 11'd5, 32'h0000_0800, FLOW_SPARE);
      run_points(100);
      set_grid(11'd100, 11'd700, 32'h0001_8000, FLOW_SECOND);
      run_points(120);
      set_grid(11'd1024, 11'd3, 32'h0000_0010, FLOW_FIRST);
      run_points(120);
      set_grid(11'd17, 11'd1024, 32'h00FF_0000, FLOW_FIRST);
      run_points(120);
      set_grid(11'd255, 11'd9, 32'd0, FLOW_SECOND);
      run_points(120);
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("upwind_convection_diffusion_stencil verification clean");
      end else begin
         $display("upwind_convection_diffusion_stencil verification failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+src
src/ucds_pkg.sv
src/upwind_convection_diffusion_stencil.sv
verif/tb_upwind_convection_diffusion_stencil.sv
